// File: rtl/dijkstra_matrix_shortest_path_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_MATRIX_SHORTEST_PATH_ASSERT_SVH
`define DIJKSTRA_MATRIX_SHORTEST_PATH_ASSERT_SVH

`ifndef SYNTH

// property holds at every edge out of reset
`define DMSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dmsp check failed");

// antecedent in one cycle implies consequent in the next
`define DMSP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmsp sequence check failed");

`else

`define DMSP_ASSERT(name, prop)
`define DMSP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: rtl/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types and constants of the shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = 6;
  localparam int WEIGHT_BITS = 16;
  localparam int VC_W        = 7;
  localparam int MAT_DEPTH   = MAX_NODES * MAX_NODES;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [VC_W-1:0]        VC_RESET = VC_W'(64);
  localparam logic [WEIGHT_BITS-1:0] NE_RESET = WEIGHT_BITS'(10000);

  // request codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // configuration register index
  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0,
    REG_NO_EDGE      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_EMIT
  } state_t;

  // one entry of the per-vertex table
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] distance;
    logic [NODE_W-1:0]      pred;
    logic                   visited;
    logic                   pvalid;
  } node_t;

  typedef struct packed {
    logic [VC_W-1:0]        vertex_count;
    logic [WEIGHT_BITS-1:0] no_edge_value;
  } cfg_regs_t;

endpackage

`default_nettype wire

// File: rtl/dmsp_ram.sv
// ----------------------------------------------------------------------------
// dmsp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/dmsp_cfg.sv
// ----------------------------------------------------------------------------
// dmsp_cfg
// APB register file: vertex count and no-edge value.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dmsp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dmsp_pkg::PDATA_W-1:0] pwdata,
  output logic      [dmsp_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output dmsp_pkg::cfg_regs_t               cfg
);

  logic [dmsp_pkg::VC_W-1:0]        vertex_count_r, vertex_count_nxt;
  logic [dmsp_pkg::WEIGHT_BITS-1:0] no_edge_r, no_edge_nxt;
  logic                             wr_en;
  dmsp_pkg::reg_idx_t               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = dmsp_pkg::reg_idx_t'(paddr[2]);

  // write decode
  always_comb begin
    vertex_count_nxt = vertex_count_r;
    no_edge_nxt      = no_edge_r;
    if (wr_en) begin
      case (reg_idx)
        dmsp_pkg::REG_VERTEX_COUNT: vertex_count_nxt = pwdata[dmsp_pkg::VC_W-1:0];
        dmsp_pkg::REG_NO_EDGE:      no_edge_nxt = pwdata[dmsp_pkg::WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= dmsp_pkg::VC_RESET;
      no_edge_r      <= dmsp_pkg::NE_RESET;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      no_edge_r      <= no_edge_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      dmsp_pkg::REG_VERTEX_COUNT:
        prdata = dmsp_pkg::PDATA_W'(vertex_count_r);
      dmsp_pkg::REG_NO_EDGE:
        prdata = dmsp_pkg::PDATA_W'(no_edge_r);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.vertex_count  = vertex_count_r;
  assign cfg.no_edge_value = no_edge_r;

endmodule

`default_nettype wire

// File: rtl/dmsp_ctrl.sv
// ----------------------------------------------------------------------------
// dmsp_ctrl
// Sequencer and datapath: weight matrix RAM, per-vertex table RAM, min scan
// and relaxation, one table entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dmsp_pkg::cfg_regs_t              cfg,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_row_vertex,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_col_vertex,
  input  wire logic [dmsp_pkg::WEIGHT_BITS-1:0] in_edge_weight,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_start_vertex,
  output logic                                  out_valid,
  output logic      [dmsp_pkg::NODE_W-1:0]      out_vertex_index,
  output logic      [dmsp_pkg::WEIGHT_BITS-1:0] out_shortest_distance,
  output logic      [dmsp_pkg::NODE_W-1:0]      out_predecessor,
  output logic                                  out_reachable,
  output logic                                  out_last_result
);

  localparam int NW  = dmsp_pkg::NODE_W;
  localparam int WB  = dmsp_pkg::WEIGHT_BITS;
  localparam int VW  = dmsp_pkg::VC_W;
  localparam int NDW = $bits(dmsp_pkg::node_t);

  dmsp_pkg::state_t state_r, state_nxt;

  logic [VW-1:0] n_r, n_nxt;
  logic [NW-1:0] s_r, s_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic          stg_v_r, stg_v_nxt;
  logic [NW-1:0] stg_idx_r, stg_idx_nxt;
  logic [NW-1:0] u_r, u_nxt;
  logic [WB-1:0] best_r, best_nxt;
  logic          have_r, have_nxt;
  logic [NW-1:0] round_r, round_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] out_idx_r, out_idx_nxt;
  logic [WB-1:0] out_dist_r, out_dist_nxt;
  logic [NW-1:0] out_pred_r, out_pred_nxt;
  logic          out_reach_r, out_reach_nxt;
  logic          out_last_r, out_last_nxt;

  // memory ports
  logic                  mat_we;
  logic [2*NW-1:0]       mat_waddr;
  logic [WB-1:0]         mat_wdata;
  logic [2*NW-1:0]       mat_raddr;
  logic [WB-1:0]         mat_rdata;
  logic                  node_we;
  logic [NW-1:0]         node_waddr;
  dmsp_pkg::node_t       node_wdata;
  logic [NW-1:0]         node_raddr;
  dmsp_pkg::node_t       node_rdata;
  logic [NDW-1:0]        node_rdata_raw;

  // derived
  logic                  accept;
  logic [VW-1:0]         n_req;
  logic [NW-1:0]         s_req;
  logic                  issue;
  logic                  phase_done;
  logic                  last_round;
  logic [WB-1:0]         w_clamp;
  logic [WB:0]           relax_sum;
  logic                  relax_win;
  logic                  stg_is_u;

  dmsp_ram #(.WIDTH(WB), .DEPTH(dmsp_pkg::MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  dmsp_ram #(.WIDTH(NDW), .DEPTH(dmsp_pkg::MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata_raw)
  );

  assign node_rdata = dmsp_pkg::node_t'(node_rdata_raw);

  assign busy   = (state_r != dmsp_pkg::ST_IDLE);
  assign accept = start & ~busy;

  // clamp vertex count to 1..MAX_NODES, start to the last vertex in use
  always_comb begin
    n_req = cfg.vertex_count;
    if (n_req == '0) begin
      n_req = VW'(1);
    end else if (n_req > VW'(dmsp_pkg::MAX_NODES)) begin
      n_req = VW'(dmsp_pkg::MAX_NODES);
    end
    s_req = in_start_vertex;
    if ({1'b0, in_start_vertex} >= n_req) begin
      s_req = NW'(n_req - VW'(1));
    end
  end

  // walk control: idx_r issues reads, stg_* holds the entry whose data is back
  assign issue      = (state_r != dmsp_pkg::ST_IDLE) && (idx_r < n_r);
  assign phase_done = stg_v_r && ({1'b0, stg_idx_r} == n_r - VW'(1));
  assign last_round = ({1'b0, round_r} + VW'(2)) == n_r;

  // weight read clamped to the no-edge value, 17-bit relaxation sum
  assign w_clamp   = (mat_rdata > cfg.no_edge_value) ? cfg.no_edge_value : mat_rdata;
  assign relax_sum = {1'b0, best_r} + {1'b0, w_clamp};
  assign relax_win = ~node_rdata.visited && (relax_sum < {1'b0, node_rdata.distance});
  assign stg_is_u  = (stg_idx_r == u_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmsp_pkg::ST_IDLE: begin
        if (accept && in_command == dmsp_pkg::CMD_RUN) begin
          state_nxt = dmsp_pkg::ST_INIT;
        end
      end
      dmsp_pkg::ST_INIT: begin
        if (phase_done) begin
          state_nxt = (n_r == VW'(1)) ? dmsp_pkg::ST_EMIT : dmsp_pkg::ST_SCAN;
        end
      end
      dmsp_pkg::ST_SCAN: begin
        if (phase_done) begin
          state_nxt = have_nxt ? dmsp_pkg::ST_RELAX : dmsp_pkg::ST_EMIT;
        end
      end
      dmsp_pkg::ST_RELAX: begin
        if (phase_done) begin
          state_nxt = last_round ? dmsp_pkg::ST_EMIT : dmsp_pkg::ST_SCAN;
        end
      end
      dmsp_pkg::ST_EMIT: begin
        if (phase_done) begin
          state_nxt = dmsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmsp_pkg::ST_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    mat_we     = 1'b0;
    mat_waddr  = {in_row_vertex, in_col_vertex};
    mat_wdata  = in_edge_weight;
    mat_raddr  = {u_r, idx_r[NW-1:0]};
    node_we    = 1'b0;
    node_waddr = stg_idx_r;
    node_wdata = node_rdata;
    node_raddr = idx_r[NW-1:0];
    case (state_r)
      dmsp_pkg::ST_IDLE: begin
        mat_we = accept && (in_command == dmsp_pkg::CMD_LOAD);
      end
      dmsp_pkg::ST_INIT: begin
        mat_raddr           = {s_r, idx_r[NW-1:0]};
        node_we             = stg_v_r;
        node_wdata.distance = (stg_idx_r == s_r) ? '0 : w_clamp;
        node_wdata.pred     = s_r;
        node_wdata.visited  = (stg_idx_r == s_r);
        node_wdata.pvalid   = 1'b1;
      end
      dmsp_pkg::ST_RELAX: begin
        node_we = stg_v_r && (stg_is_u || relax_win);
        if (stg_is_u) begin
          // chosen vertex: mark visited, drop predecessor if unreachable
          node_wdata.visited = 1'b1;
          node_wdata.pvalid  = (node_rdata.distance != cfg.no_edge_value);
        end else begin
          node_wdata.distance = relax_sum[WB-1:0];
          node_wdata.pred     = u_r;
        end
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    n_nxt       = n_r;
    s_nxt       = s_r;
    idx_nxt     = idx_r;
    stg_v_nxt   = issue;
    stg_idx_nxt = idx_r[NW-1:0];
    u_nxt       = u_r;
    best_nxt    = best_r;
    have_nxt    = (state_r == dmsp_pkg::ST_SCAN) ? have_r : 1'b0;
    round_nxt   = round_r;

    if (accept) begin
      n_nxt     = n_req;
      s_nxt     = s_req;
      idx_nxt   = '0;
      round_nxt = '0;
    end else if (phase_done) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + VW'(1);
    end

    // minimum search over unvisited vertices, lowest index wins ties
    if (state_r == dmsp_pkg::ST_SCAN && stg_v_r && ~node_rdata.visited &&
        (~have_r || node_rdata.distance < best_r)) begin
      have_nxt = 1'b1;
      best_nxt = node_rdata.distance;
      u_nxt    = stg_idx_r;
    end

    if (state_r == dmsp_pkg::ST_RELAX && phase_done) begin
      round_nxt = round_r + NW'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = (state_r == dmsp_pkg::ST_EMIT) && stg_v_r;
    out_idx_nxt   = stg_idx_r;
    out_dist_nxt  = node_rdata.distance;
    out_pred_nxt  = node_rdata.pvalid ? node_rdata.pred : '0;
    out_reach_nxt = node_rdata.pvalid;
    out_last_nxt  = phase_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmsp_pkg::ST_IDLE;
      idx_r       <= '0;
      stg_v_r     <= 1'b0;
      have_r      <= 1'b0;
      round_r     <= '0;
      n_r         <= VW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      stg_v_r     <= stg_v_nxt;
      have_r      <= have_nxt;
      round_r     <= round_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    stg_idx_r   <= stg_idx_nxt;
    u_r         <= u_nxt;
    best_r      <= best_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
    out_pred_r  <= out_pred_nxt;
    out_reach_r <= out_reach_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_vertex_index      = out_idx_r;
  assign out_shortest_distance = out_dist_r;
  assign out_predecessor       = out_pred_r;
  assign out_reachable         = out_reach_r;
  assign out_last_result       = out_last_r;

  // checks
`include "dijkstra_matrix_shortest_path_assert.svh"

  `DMSP_ASSERT(a_result_only_after_emit, !out_valid_r || $past(state_r) == dmsp_pkg::ST_EMIT)
  `DMSP_ASSERT(a_weight_write_when_idle, !mat_we || state_r == dmsp_pkg::ST_IDLE)
  `DMSP_ASSERT(a_table_write_when_busy, !node_we || state_r != dmsp_pkg::ST_IDLE)
  `DMSP_ASSERT_NEXT(a_last_ends_run, out_valid_r && out_last_r, !out_valid_r)

endmodule

`default_nettype wire

// File: rtl/dijkstra_matrix_shortest_path.sv
// ----------------------------------------------------------------------------
// dijkstra_matrix_shortest_path
// Single-source shortest paths over a dense weight matrix held in RAM.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// in_*      start & !busy         command, row/col vertex, weight, start vertex
// out_*     out_valid (1 cycle)   vertex, distance, predecessor, reachable, last
// cfg       APB psel/penable      vertex count, no-edge value
//
// A load request writes the matrix when accepted; busy stays low.
// A run over n vertices holds busy for 2*n passes (init, n-1 scan/relax
// pairs, results), each walking the table one entry per cycle.
// Results are registered; the last one shows in the first idle cycle.
// rst_n is synchronous; memories need no clearing.
// The result side cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module dijkstra_matrix_shortest_path (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_row_vertex,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_col_vertex,
  input  wire logic [dmsp_pkg::WEIGHT_BITS-1:0] in_edge_weight,
  input  wire logic [dmsp_pkg::NODE_W-1:0]      in_start_vertex,
  // result channel
  output logic                                  out_valid,
  output logic      [dmsp_pkg::NODE_W-1:0]      out_vertex_index,
  output logic      [dmsp_pkg::WEIGHT_BITS-1:0] out_shortest_distance,
  output logic      [dmsp_pkg::NODE_W-1:0]      out_predecessor,
  output logic                                  out_reachable,
  output logic                                  out_last_result,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dmsp_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [dmsp_pkg::PDATA_W-1:0]     pwdata,
  output logic      [dmsp_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  dmsp_pkg::cfg_regs_t cfg;

  dmsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmsp_ctrl u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_row_vertex         (in_row_vertex),
    .in_col_vertex         (in_col_vertex),
    .in_edge_weight        (in_edge_weight),
    .in_start_vertex       (in_start_vertex),
    .out_valid             (out_valid),
    .out_vertex_index      (out_vertex_index),
    .out_shortest_distance (out_shortest_distance),
    .out_predecessor       (out_predecessor),
    .out_reachable         (out_reachable),
    .out_last_result       (out_last_result)
  );

endmodule

`default_nettype wire

// File: tb/dijkstra_matrix_shortest_path_tb.sv
// ----------------------------------------------------------------------------
// Testbench for dijkstra_matrix_shortest_path
// Loads weight matrices through the request channel, runs searches from
// chosen start vertices and checks every per-vertex result, either against a
// behavioral shortest-path solver kept in step with the loaded weights and
// the register settings or against a result typed into the table. Opens
// with a short directed table, then random phases with fresh register settings each.
// ----------------------------------------------------------------------------
module dijkstra_matrix_shortest_path_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmsp_pkg::*;

  localparam int STALL_LIMIT = 30000;
  localparam int RAND_ITEMS  = 370;

  // one per-vertex result of a search
  typedef struct packed {
    logic [NODE_W-1:0]      vtx;
    logic [WEIGHT_BITS-1:0] distance;
    logic [NODE_W-1:0]      pred;
    logic                   reach;
    logic                   last;
  } path_res_t;

  typedef enum logic [1:0] {
    DS_CFG,
    DS_LOAD,
    DS_RUN
  } step_op_e;

  // one row of the directed table
  typedef struct packed {
    step_op_e               op;
    reg_idx_t               reg_sel;
    logic [PDATA_W-1:0]     data;
    logic [NODE_W-1:0]      row;
    logic [NODE_W-1:0]      col;
    logic [WEIGHT_BITS-1:0] wt;
    logic [NODE_W-1:0]      sv;
    logic                   typed;
    path_res_t              want;
  } dir_step_t;

  localparam path_res_t NO_RES   = '0;
  localparam path_res_t LONE_RES = '{6'd0, 16'd0, 6'd0, 1'b1, 1'b1};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_command = CMD_LOAD;
  logic [NODE_W-1:0]      in_row_vertex = '0;
  logic [NODE_W-1:0]      in_col_vertex = '0;
  logic [WEIGHT_BITS-1:0] in_edge_weight = '0;
  logic [NODE_W-1:0]      in_start_vertex = '0;
  logic                   out_valid;
  logic [NODE_W-1:0]      out_vertex_index;
  logic [WEIGHT_BITS-1:0] out_shortest_distance;
  logic [NODE_W-1:0]      out_predecessor;
  logic                   out_reachable;
  logic                   out_last_result;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  // solver state: loaded weights, which entries were loaded, registers
  logic [WEIGHT_BITS-1:0] weights [MAT_DEPTH];
  bit                     loaded [MAT_DEPTH];
  logic [VC_W-1:0]        vc_cfg = VC_RESET;
  logic [WEIGHT_BITS-1:0] ne_cfg = NE_RESET;

  path_res_t exp_paths [$];

  int  mismatches = 0;
  int  n_checked = 0;
  int  n_loads = 0;
  int  n_runs = 0;
  int  n_settings = 0;
  int  max_graph = 0;
  int  stall_cycles = 0;
  bit  idle_on = 1'b1;

  dijkstra_matrix_shortest_path uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_row_vertex        (in_row_vertex),
    .in_col_vertex        (in_col_vertex),
    .in_edge_weight       (in_edge_weight),
    .in_start_vertex      (in_start_vertex),
    .out_valid            (out_valid),
    .out_vertex_index     (out_vertex_index),
    .out_shortest_distance(out_shortest_distance),
    .out_predecessor      (out_predecessor),
    .out_reachable        (out_reachable),
    .out_last_result      (out_last_result),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #5 clk = ~clk;

  // count a failure, print only the first few
  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // vertex count as the block uses it
  function automatic int eff_count();
    int n;
    n = vc_cfg;
    if (n == 0) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  // stored weight, clipped to the no-edge value
  function automatic logic [WEIGHT_BITS-1:0] edge_cost(int r, int c);
    logic [WEIGHT_BITS-1:0] w;
    w = weights[r * MAX_NODES + c];
    return (w > ne_cfg) ? ne_cfg : w;
  endfunction

  // full search from sv; queues one result per vertex in index order
  task automatic solve_paths(logic [NODE_W-1:0] sv);
    logic [WEIGHT_BITS-1:0] dist_v [MAX_NODES];
    logic [NODE_W-1:0]      pred_v [MAX_NODES];
    bit                     seen [MAX_NODES];
    bit                     pvalid [MAX_NODES];
    logic [WEIGHT_BITS-1:0] best;
    logic [WEIGHT_BITS:0]   sum;
    path_res_t              res;
    int n, s, u, i, w, round;
    bit have;
    n = eff_count();
    s = sv;
    if (s >= n) s = n - 1;
    if (n > max_graph) max_graph = n;
    for (i = 0; i < n; i++) begin
      dist_v[i] = edge_cost(s, i);
      seen[i]   = 1'b0;
      pred_v[i] = NODE_W'(s);
      pvalid[i] = 1'b1;
    end
    seen[s]   = 1'b1;
    dist_v[s] = '0;
    for (round = 0; round + 1 < n; round++) begin
      // closest unvisited vertex, lowest index on ties
      have = 1'b0;
      best = '0;
      u    = 0;
      for (i = 0; i < n; i++) begin
        if (!seen[i] && (!have || dist_v[i] < best)) begin
          have = 1'b1;
          best = dist_v[i];
          u    = i;
        end
      end
      if (!have) break;
      seen[u] = 1'b1;
      // relax with a sum one bit wider than a weight
      for (w = 0; w < n; w++) begin
        if (!seen[w]) begin
          sum = {1'b0, dist_v[u]} + {1'b0, edge_cost(u, w)};
          if (sum < {1'b0, dist_v[w]}) begin
            dist_v[w] = sum[WEIGHT_BITS-1:0];
            pred_v[w] = NODE_W'(u);
          end
        end
      end
      if (dist_v[u] == ne_cfg) pvalid[u] = 1'b0;
    end
    for (i = 0; i < n; i++) begin
      res.vtx      = NODE_W'(i);
      res.distance = dist_v[i];
      res.pred     = pvalid[i] ? pred_v[i] : '0;
      res.reach    = pvalid[i];
      res.last     = (i + 1 == n);
      exp_paths.push_back(res);
    end
  endtask

  // one request: optional idle gap, then hold until accepted
  task automatic issue(logic cmd, logic [NODE_W-1:0] row, logic [NODE_W-1:0] col,
                       logic [WEIGHT_BITS-1:0] wt, logic [NODE_W-1:0] sv, bit predict);
    if (idle_on && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_row_vertex   <= row;
    in_col_vertex   <= col;
    in_edge_weight  <= wt;
    in_start_vertex <= sv;
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd == CMD_LOAD) begin
      weights[{row, col}] = wt;
      loaded[{row, col}]  = 1'b1;
      n_loads++;
    end else begin
      n_runs++;
      if (predict) solve_paths(sv);
    end
  endtask

  // hold requests off until every result is in and the block is idle
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (exp_paths.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one APB transfer: setup, access until pready, then idle
  task automatic apb_access(reg_idx_t idx, logic wr, logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(reg_idx_t idx);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] want;
    want = (idx == REG_VERTEX_COUNT) ? PDATA_W'(vc_cfg) : PDATA_W'(ne_cfg);
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== want) begin
      flag($sformatf("register %s read %h, expected %h", idx.name(), rd, want));
    end
  endtask

  task automatic set_register(reg_idx_t idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    settle_idle();
    apb_access(idx, 1'b1, val, rd);
    if (idx == REG_VERTEX_COUNT) vc_cfg = val[VC_W-1:0];
    else ne_cfg = val[WEIGHT_BITS-1:0];
    n_settings++;
    check_register(idx);
  endtask

  // mix of small weights, no-edge and weights above no-edge
  function automatic logic [WEIGHT_BITS-1:0] pick_weight(logic [WEIGHT_BITS-1:0] ne);
    logic [WEIGHT_BITS-1:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = ne;
      2: w = (ne == 16'hFFFF) ? ne : WEIGHT_BITS'($urandom_range(ne + 1, 65535));
      3: w = 16'hFFFF;
      4: w = WEIGHT_BITS'($urandom_range(1, (ne < 40) ? ne : 40));
      default: w = WEIGHT_BITS'($urandom_range(0, ne));
    endcase
    return w;
  endfunction

  // load every entry of the n x n square not yet written, mostly no-edge
  task automatic fill_square(int n);
    int r, c;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        if (!loaded[r * MAX_NODES + c]) begin
          issue(CMD_LOAD, NODE_W'(r), NODE_W'(c),
                ($urandom_range(0, 2) == 0) ? pick_weight(ne_cfg) : ne_cfg,
                NODE_W'($urandom), 1'b1);
        end
      end
    end
  endtask

  // result checker: a result is accepted at the edge that ends its cycle
  always @(posedge clk) begin : result_check
    path_res_t got;
    path_res_t want;
    if (rst_n && out_valid) begin
      got = {out_vertex_index, out_shortest_distance, out_predecessor,
             out_reachable, out_last_result};
      if (exp_paths.size() == 0) begin
        flag($sformatf("unexpected result: vertex %0d dist %0d pred %0d reach %b last %b",
                       got.vtx, got.distance, got.pred, got.reach, got.last));
      end else begin
        want = exp_paths.pop_front();
        n_checked++;
        if (got.vtx !== want.vtx || got.distance !== want.distance ||
            got.pred !== want.pred || got.reach !== want.reach ||
            got.last !== want.last) begin
          flag($sformatf("vertex/dist/pred/reach/last expected %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                         want.vtx, want.distance, want.pred, want.reach, want.last,
                         got.vtx, got.distance, got.pred, got.reach, got.last));
        end
      end
    end
  end

  // watchdog: cycles with no request and no result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // directed table: extremes, both commands, clipping and unreachable cases
  dir_step_t dir_steps [24] = '{
    // one vertex, upper register bits set; start beyond range folds to last
    '{DS_CFG,  REG_VERTEX_COUNT, 32'hFFFF_FF81, 6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'hFFFF,  6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd63, 1'b1, LONE_RES},
    // zero vertex count acts as one
    '{DS_CFG,  REG_VERTEX_COUNT, 32'h0000_0080, 6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd0,  1'b1, LONE_RES},
    // two vertices, one unreachable from vertex 0
    '{DS_CFG,  REG_VERTEX_COUNT, 32'd2,         6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd1, 16'd10000, 6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd1, 6'd0, 16'd5,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd1, 6'd1, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd1,  1'b0, NO_RES},
    // smallest no-edge value: weights above it clip
    '{DS_CFG,  REG_NO_EDGE,      32'hABCD_0001, 6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd1, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    // largest no-edge value, sums past 16 bits
    '{DS_CFG,  REG_NO_EDGE,      32'h0000_FFFF, 6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_CFG,  REG_VERTEX_COUNT, 32'd3,         6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd2, 16'd65534, 6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd1, 6'd2, 16'd65535, 6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd2, 6'd0, 16'd65535, 6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd2, 6'd1, 16'd65534, 6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd2, 6'd2, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_LOAD, REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd1, 16'd65535, 6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd0,  1'b0, NO_RES},
    '{DS_RUN,  REG_VERTEX_COUNT, 32'd0,         6'd0, 6'd0, 16'd0,     6'd5,  1'b0, NO_RES}
  };

  initial begin : stimulus
    int i, n, phase, r;
    logic [NODE_W-1:0] row, col;
    logic [VC_W-1:0] vc_val;
    logic [WEIGHT_BITS-1:0] ne_val;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values out of reset
    check_register(REG_VERTEX_COUNT);
    check_register(REG_NO_EDGE);

    // directed table
    for (i = 0; i < 24; i++) begin
      case (dir_steps[i].op)
        DS_CFG: begin
          set_register(dir_steps[i].reg_sel, dir_steps[i].data);
        end
        DS_LOAD: begin
          issue(CMD_LOAD, dir_steps[i].row, dir_steps[i].col, dir_steps[i].wt,
                dir_steps[i].sv, 1'b1);
        end
        default: begin
          issue(CMD_RUN, dir_steps[i].row, dir_steps[i].col, dir_steps[i].wt,
                dir_steps[i].sv, !dir_steps[i].typed);
          if (dir_steps[i].typed) exp_paths.push_back(dir_steps[i].want);
        end
      endcase
    end

    // random phases, each with its own register settings; phase 1 adds no idle gaps
    phase = 0;
    while (n_loads + n_runs < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) vc_val = VC_W'($urandom_range(0, 1));
      else if (r < 85) vc_val = VC_W'($urandom_range(2, 8));
      else vc_val = VC_W'($urandom_range(9, 12));
      case ($urandom_range(0, 4))
        0: ne_val = 16'd1;
        1: ne_val = 16'd10000;
        2: ne_val = 16'hFFFF;
        3: ne_val = WEIGHT_BITS'($urandom_range(2, 300));
        default: ne_val = WEIGHT_BITS'($urandom_range(1, 65535));
      endcase
      set_register(REG_VERTEX_COUNT, {25'($urandom), vc_val});
      set_register(REG_NO_EDGE, {16'($urandom), ne_val});
      n = eff_count();
      idle_on = (phase != 1);
      repeat ($urandom_range(15, 40)) begin
        if (n_loads + n_runs >= RAND_ITEMS) break;
        if ($urandom_range(0, 99) < 5) settle_idle();
        if ($urandom_range(0, 99) < 22) begin
          fill_square(n);
          issue(CMD_RUN, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_BITS'($urandom),
                ($urandom_range(0, 9) < 8) ? NODE_W'($urandom_range(0, n - 1))
                                           : NODE_W'($urandom), 1'b1);
        end else begin
          if ($urandom_range(0, 9) < 7) begin
            row = NODE_W'($urandom_range(0, n - 1));
            col = NODE_W'($urandom_range(0, n - 1));
          end else begin
            row = NODE_W'($urandom);
            col = NODE_W'($urandom);
          end
          issue(CMD_LOAD, row, col, pick_weight(ne_cfg), NODE_W'($urandom), 1'b1);
        end
      end
      phase++;
    end
    idle_on = 1'b1;

    // drain and let the block settle
    settle_idle();
    repeat (16) @(posedge clk);
    if (exp_paths.size() != 0) begin
      flag($sformatf("%0d results never arrived", exp_paths.size()));
    end

    $display("Ran %0d weight loads and %0d searches over %0d register settings;",
             n_loads, n_runs, n_settings);
    $display("checked %0d per-vertex results, graphs up to %0d vertices, %0d mismatches.",
             n_checked, max_graph, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
